@@ hdl/cfawc_pkg.sv @@
// Shared constants, register indexes and the back-end state type for the
// ceiling-from-average block. No dependencies.
package cfawc_pkg;

  localparam int MAX_GROUP_DEF     = 32;
  localparam int TABLE_ENTRIES_DEF = 4;

  localparam int DATA_W      = 32;  // reading, sum, key and speed width
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int ENTRY_CNT_W = 3;

  // divider retires this many quotient bits per cycle
  localparam int DIV_STEP   = 4;
  localparam int DIV_CYCLES = DATA_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CEIL   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_CMP,
    ST_WALK,
    ST_DONE
  } back_state_t;

endpackage

@@ hdl/ceiling_from_average_with_crossing.sv @@
// Input words are taken one per cycle whenever the two-group queue between
// the accumulator and the evaluator has room; only the last word of a group
// produces a result. A group is evaluated by the 4-bit-per-cycle divider and
// then the one-entry-per-cycle table walk over up to TABLE_ENTRIES entries;
// a group with no present reading skips the divider and the walk. The
// result register decouples the output so evaluation of the next group may
// start while a result waits. The user must write config only while the
// block is idle; the block does not enforce this. A write of initial_ceiling
// also loads the current ceiling.
// Top level: instantiates cfawc_front, cfawc_fifo and cfawc_back.
module ceiling_from_average_with_crossing #(
  parameter int MAX_GROUP     = cfawc_pkg::MAX_GROUP_DEF,
  parameter int TABLE_ENTRIES = cfawc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [cfawc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cfawc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cfawc_pkg::DATA_W-1:0]  in_sample_value,
  input  logic                                 in_sample_present,
  input  logic                                 in_last_in_group,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cfawc_pkg::DATA_W-1:0]         out_ceiling_speed,
  output logic                                 out_average_valid
);

  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int QW = cfawc_pkg::DATA_W + CW;

  logic                          q_push;
  logic                          q_pop;
  logic                          q_full;
  logic                          q_empty;
  logic [cfawc_pkg::DATA_W-1:0]  push_sum;
  logic [CW-1:0]                 push_count;
  logic [QW-1:0]                 pop_word;

  cfawc_front #(
    .MAX_GROUP (MAX_GROUP)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_value   (in_sample_value),
    .in_sample_present (in_sample_present),
    .in_last_in_group  (in_last_in_group),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_sum             (push_sum),
    .q_count           (push_count)
  );

  cfawc_fifo #(
    .DW (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_sum, push_count}),
    .pop       (q_pop),
    .pop_data  (pop_word),
    .full      (q_full),
    .empty     (q_empty)
  );

  cfawc_back #(
    .MAX_GROUP     (MAX_GROUP),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .grp_valid         (!q_empty),
    .grp_sum           (pop_word[QW-1:CW]),
    .grp_count         (pop_word[CW-1:0]),
    .grp_pop           (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ceiling_speed (out_ceiling_speed),
    .out_average_valid (out_average_valid)
  );

endmodule

@@ hdl/cfawc_front.sv @@
// Front end: accepts input words, sums and counts present readings and
// hands a (sum, count) pair per group to the queue. Uses cfawc_pkg.
module cfawc_front #(
  parameter int MAX_GROUP = cfawc_pkg::MAX_GROUP_DEF,
  localparam int CW = $clog2(MAX_GROUP + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [cfawc_pkg::DATA_W-1:0] in_sample_value,
  input  logic                           in_sample_present,
  input  logic                           in_last_in_group,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [cfawc_pkg::DATA_W-1:0]   q_sum,
  output logic [CW-1:0]                  q_count
);

  logic [cfawc_pkg::DATA_W-1:0] sum_r, sum_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic                         take;
  logic                         accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  // readings past the group limit are dropped
  assign take     = in_sample_present && (cnt_r < CW'(MAX_GROUP));

  always_comb begin
    sum_nxt = take ? (sum_r + in_sample_value) : sum_r;
    cnt_nxt = take ? (cnt_r + CW'(1)) : cnt_r;
  end

  assign q_push  = accept && in_last_in_group;
  assign q_sum   = sum_nxt;
  assign q_count = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (accept) begin
      if (in_last_in_group) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

@@ hdl/cfawc_fifo.sv @@
// Two-entry queue of finished groups between front and back end.
// No package dependencies.
module cfawc_fifo #(
  parameter int DW = 38
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          full,
  output logic          empty
);

  logic [DW-1:0] mem_r [0:1];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ hdl/cfawc_back.sv @@
// Back end: divides each group's sum by its count, walks the key/speed
// table and drives the result register. Holds the config registers.
// Uses cfawc_pkg.
module cfawc_back #(
  parameter int MAX_GROUP     = cfawc_pkg::MAX_GROUP_DEF,
  parameter int TABLE_ENTRIES = cfawc_pkg::TABLE_ENTRIES_DEF,
  localparam int CW = $clog2(MAX_GROUP + 1),
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cfawc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cfawc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                grp_valid,
  input  logic [cfawc_pkg::DATA_W-1:0]        grp_sum,
  input  logic [CW-1:0]                       grp_count,
  output logic                                grp_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cfawc_pkg::DATA_W-1:0]        out_ceiling_speed,
  output logic                                out_average_valid
);

  localparam int DW  = cfawc_pkg::DATA_W;
  localparam int ECW = cfawc_pkg::ENTRY_CNT_W;

  cfawc_pkg::back_state_t state_r, state_nxt;

  logic [cfawc_pkg::CFG_DATA_W-1:0] table_r [0:TABLE_ENTRIES-1];
  logic [ECW-1:0]                   entry_count_r;
  logic [DW-1:0]                    cur_ceil_r;
  logic signed [DW-1:0]             prev_key_r;
  logic signed [DW-1:0]             old_key_r;
  logic signed [DW-1:0]             avg_r;

  logic [CW-1:0]                    rem_r, rem_nxt;
  logic [DW-1:0]                    dq_r, dq_nxt;
  logic [CW-1:0]                    divisor_r;
  logic                             neg_r;
  logic [cfawc_pkg::DIV_CNT_W-1:0]  div_cnt_r;
  logic                             avg_valid_r;

  logic [IW-1:0]                    walk_idx_r;
  logic                             walk_down_r;

  logic                             out_valid_r;
  logic [DW-1:0]                    out_speed_r;
  logic                             out_avg_valid_r;

  logic [ECW-1:0]                   n_use;
  logic signed [DW-1:0]             key_cur;
  logic [DW-1:0]                    spd_cur;
  logic                             at_top;
  logic                             at_bot;
  logic                             walk_hit;
  logic                             walk_upd;
  logic                             walk_done;
  logic                             div_last;
  logic                             out_free;
  logic                             out_load;
  logic                             skip_walk;

  assign n_use = (entry_count_r > ECW'(TABLE_ENTRIES)) ? ECW'(TABLE_ENTRIES) : entry_count_r;

  // restoring division, DIV_STEP quotient bits per cycle
  always_comb begin
    logic [CW:0] t;
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    for (int k = 0; k < cfawc_pkg::DIV_STEP; k++) begin
      t = {rem_nxt, dq_nxt[DW-1]};
      if (t >= {1'b0, divisor_r}) begin
        rem_nxt = CW'(t - {1'b0, divisor_r});
        dq_nxt  = {dq_nxt[DW-2:0], 1'b1};
      end else begin
        rem_nxt = CW'(t);
        dq_nxt  = {dq_nxt[DW-2:0], 1'b0};
      end
    end
  end

  assign div_last = (div_cnt_r == cfawc_pkg::DIV_CNT_W'(cfawc_pkg::DIV_CYCLES - 1));

  // one table entry per cycle; a boundary entry ends the walk at once
  assign key_cur = $signed(table_r[walk_idx_r][63:32]);
  assign spd_cur = table_r[walk_idx_r][DW-1:0];
  assign at_top  = (ECW'(walk_idx_r) == (n_use - ECW'(1)));
  assign at_bot  = (walk_idx_r == '0);
  assign walk_hit = (at_top && (avg_r >= key_cur)) || (at_bot && (avg_r <= key_cur));

  always_comb begin
    if (walk_down_r) begin
      walk_upd  = (avg_r < key_cur) && (key_cur <= old_key_r);
      walk_done = walk_hit || at_bot;
    end else begin
      walk_upd  = (avg_r > key_cur) && (key_cur >= old_key_r);
      walk_done = walk_hit || at_top;
    end
  end

  assign skip_walk = (n_use == '0) || (avg_r == prev_key_r);
  assign out_free  = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfawc_pkg::ST_IDLE: begin
        if (grp_valid) begin
          state_nxt = (grp_count == '0) ? cfawc_pkg::ST_DONE : cfawc_pkg::ST_DIV;
        end
      end
      cfawc_pkg::ST_DIV: begin
        if (div_last) begin
          state_nxt = cfawc_pkg::ST_SIGN;
        end
      end
      cfawc_pkg::ST_SIGN: state_nxt = cfawc_pkg::ST_CMP;
      cfawc_pkg::ST_CMP: begin
        state_nxt = skip_walk ? cfawc_pkg::ST_DONE : cfawc_pkg::ST_WALK;
      end
      cfawc_pkg::ST_WALK: begin
        if (walk_done) begin
          state_nxt = cfawc_pkg::ST_DONE;
        end
      end
      cfawc_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = cfawc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cfawc_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    grp_pop  = 1'b0;
    out_load = 1'b0;
    case (state_r)
      cfawc_pkg::ST_IDLE: grp_pop  = grp_valid;
      cfawc_pkg::ST_DONE: out_load = out_free;
      default: begin
        grp_pop  = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // control and config state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= cfawc_pkg::ST_IDLE;
      entry_count_r <= '0;
      cur_ceil_r    <= '1;
      prev_key_r    <= '0;
      out_valid_r   <= 1'b0;
      for (int j = 0; j < TABLE_ENTRIES; j++) begin
        table_r[j] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        if (cfg_index == cfawc_pkg::REG_ENTRY_COUNT) begin
          entry_count_r <= cfg_data[ECW-1:0];
        end
        if (cfg_index == cfawc_pkg::REG_INIT_CEIL) begin
          cur_ceil_r <= cfg_data[DW-1:0];
        end
        for (int j = 0; j < TABLE_ENTRIES; j++) begin
          if (cfg_index == (cfawc_pkg::REG_TABLE_0 + cfawc_pkg::CFG_IDX_W'(j))) begin
            table_r[j] <= cfg_data;
          end
        end
      end

      if (state_r == cfawc_pkg::ST_CMP) begin
        prev_key_r <= avg_r;
      end
      if ((state_r == cfawc_pkg::ST_WALK) && (walk_hit || walk_upd)) begin
        cur_ceil_r <= spd_cur;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      cfawc_pkg::ST_IDLE: begin
        divisor_r   <= grp_count;
        neg_r       <= grp_sum[DW-1];
        dq_r        <= grp_sum[DW-1] ? (~grp_sum + DW'(1)) : grp_sum;
        rem_r       <= '0;
        div_cnt_r   <= '0;
        avg_valid_r <= (grp_count != '0);
      end
      cfawc_pkg::ST_DIV: begin
        rem_r     <= rem_nxt;
        dq_r      <= dq_nxt;
        div_cnt_r <= div_cnt_r + cfawc_pkg::DIV_CNT_W'(1);
      end
      cfawc_pkg::ST_SIGN: begin
        avg_r <= neg_r ? $signed(~dq_r + DW'(1)) : $signed(dq_r);
      end
      cfawc_pkg::ST_CMP: begin
        old_key_r   <= prev_key_r;
        walk_down_r <= (avg_r < prev_key_r);
        walk_idx_r  <= (avg_r < prev_key_r) ? IW'(n_use - ECW'(1)) : '0;
      end
      cfawc_pkg::ST_WALK: begin
        walk_idx_r <= walk_down_r ? (walk_idx_r - IW'(1)) : (walk_idx_r + IW'(1));
      end
      default: begin
        if (out_load) begin
          out_speed_r     <= cur_ceil_r;
          out_avg_valid_r <= avg_valid_r;
        end
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_ceiling_speed = out_speed_r;
  assign out_average_valid = out_avg_valid_r;

endmodule

@@ hdl/cfawc_checker.sv @@
// Port-level checks for ceiling_from_average_with_crossing, attached by bind.
// Uses cfawc_pkg for widths.
module cfawc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cfawc_pkg::DATA_W-1:0] out_ceiling_speed,
  input logic                         out_average_valid
);

  // a waiting result word is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_ceiling_speed) && $stable(out_average_valid))
    else $error("out word changed while stalled");

  // reset empties the result register and the group queue
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("in_ready low after reset");

endmodule

bind ceiling_from_average_with_crossing cfawc_checker u_cfawc_checker (.*);

@@ tb/sv/tb_ceiling_from_average_with_crossing.sv @@
// Self-checking testbench for ceiling_from_average_with_crossing: drives reading words,
// predicts the ceiling of every group in a local model and checks each result word.
// Depends on cfawc_pkg and the block's RTL only.
module tb_ceiling_from_average_with_crossing;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_GAP       = 18;

  localparam logic [cfawc_pkg::CFG_IDX_W-1:0] REG_TABLE_3 = cfawc_pkg::REG_TABLE_0 + 3'd3;
  localparam logic [cfawc_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [cfawc_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [cfawc_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [cfawc_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic signed [cfawc_pkg::DATA_W-1:0] in_sample_value = '0;
  logic                                in_sample_present = 1'b0;
  logic                                in_last_in_group = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [cfawc_pkg::DATA_W-1:0]        out_ceiling_speed;
  logic                                out_average_valid;

  // local copy of the block's registers and state
  logic [2:0]             cfg_entries = '0;
  logic [63:0]            key_table [4] = '{default: '0};
  logic [31:0]            acc_sum = '0;
  int                     acc_count = 0;
  logic [31:0]            last_avg = '0;
  logic [31:0]            ceil_now = 32'hFFFF_FFFF;

  // expected result words, oldest first
  logic [31:0]            exp_ceiling [$];
  bit                     exp_valid [$];

  int  errors = 0;
  int  words_sent = 0;
  int  results_checked = 0;
  int  reg_writes = 0;
  int  cycle_count = 0;
  bit  idle_on = 1'b1;
  int  hold_req = 0;

  ceiling_from_average_with_crossing u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_value   (in_sample_value),
    .in_sample_present (in_sample_present),
    .in_last_in_group  (in_last_in_group),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ceiling_speed (out_ceiling_speed),
    .out_average_valid (out_average_valid)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, exp_ceiling.size());
      $display("tb_ceiling_from_average_with_crossing NOT OK");
      $finish;
    end
  end

  // table walk toward the new average; returns the new ceiling
  function automatic logic [31:0] choose_ceiling(longint avg, longint old_key,
                                                 logic [31:0] speed);
    int     n;
    longint key;
    logic [31:0] spd;
    n = (cfg_entries > cfawc_pkg::TABLE_ENTRIES_DEF) ? cfawc_pkg::TABLE_ENTRIES_DEF
                                                     : int'(cfg_entries);
    spd = speed;
    if (n == 0 || avg == old_key) return speed;
    if (avg < old_key) begin
      for (int i = n - 1; i >= 0; i--) begin
        key = longint'($signed(key_table[i][63:32]));
        if (i == n - 1 && avg >= key) return key_table[i][31:0];
        else if (i == 0 && avg <= key) return key_table[i][31:0];
        if (avg < key && key <= old_key) spd = key_table[i][31:0];
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        key = longint'($signed(key_table[i][63:32]));
        if (i == 0 && avg <= key) return key_table[i][31:0];
        else if (i == n - 1 && avg >= key) return key_table[i][31:0];
        if (avg > key && key >= old_key) spd = key_table[i][31:0];
      end
    end
    return spd;
  endfunction

  function automatic void accumulate_word(logic [31:0] v, bit p, bit l);
    longint avg;
    longint old_key;
    if (p && acc_count < cfawc_pkg::MAX_GROUP_DEF) begin
      acc_sum = acc_sum + v;
      acc_count++;
    end
    if (l) begin
      if (acc_count > 0) begin
        avg = longint'($signed(acc_sum)) / longint'(acc_count);
        old_key = longint'($signed(last_avg));
        last_avg = avg[31:0];
        ceil_now = choose_ceiling(avg, old_key, ceil_now);
      end
      exp_ceiling.push_back(ceil_now);
      exp_valid.push_back(acc_count > 0);
      acc_sum = '0;
      acc_count = 0;
    end
  endfunction

  // every call starts at a rising edge; valid stays high across back-to-back words
  task automatic send_word(logic [31:0] v, bit p, bit l);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_sample_value   <= v;
    in_sample_present <= p;
    in_last_in_group  <= l;
    do @(posedge clk); while (!in_ready);
    accumulate_word(v, p, l);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (exp_ceiling.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [cfawc_pkg::CFG_IDX_W-1:0] idx,
                           logic [cfawc_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == cfawc_pkg::REG_ENTRY_COUNT) begin
      cfg_entries = val[2:0];
    end else if (idx >= cfawc_pkg::REG_TABLE_0 && idx <= REG_TABLE_3) begin
      key_table[idx - cfawc_pkg::REG_TABLE_0] = val;
    end else if (idx == cfawc_pkg::REG_INIT_CEIL) begin
      ceil_now  = val[31:0];
    end
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic write_entry(int i, logic [31:0] key, logic [31:0] speed);
    write_reg(cfawc_pkg::CFG_IDX_W'(cfawc_pkg::REG_TABLE_0 + i), {key, speed});
  endtask

  // readings mostly land near a table key so averages cross entries
  function automatic logic [31:0] rand_reading();
    int pick;
    logic [31:0] center;
    pick = $urandom_range(0, 15);
    if (pick == 0) return $urandom;
    if (pick == 1) return 32'h8000_0000;
    if (pick == 2) return 32'h7FFF_FFFF;
    center = key_table[$urandom_range(0, 3)][63:32];
    return center + 32'(int'($urandom_range(0, 80)) - 40);
  endfunction

  task automatic load_random_table();
    int mode;
    int pick;
    logic [31:0] key;
    logic [63:0] val;
    mode = $urandom_range(0, 5);
    key = 32'(int'($urandom_range(0, 2000)) - 1000);
    for (int i = 0; i < 4; i++) begin
      if (mode == 0) key = 32'h8000_0000 + 32'(i) * 32'h4000_0000 + ($urandom & 32'h3FFF_FFFF);
      else if (mode == 1) key = 32'(int'($urandom_range(0, 400)) - 200);
      else if (i > 0) key = key + $urandom_range(0, 300);  // step 0 makes a duplicate key
      write_entry(i, key, $urandom);
    end
    pick = $urandom_range(0, 9);
    val = {$urandom, $urandom};
    val[2:0] = (pick < 6) ? 3'd4 : 3'($urandom_range(0, 7));
    write_reg(cfawc_pkg::REG_ENTRY_COUNT, val);
    pick = $urandom_range(0, 5);
    if (pick < 2) begin
      val = {$urandom, $urandom};
      if (pick == 0) val[31:0] = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
      write_reg(cfawc_pkg::REG_INIT_CEIL, val);
    end
  endtask

  task automatic send_random_group();
    int kind;
    int len;
    bit p;
    kind = $urandom_range(0, 19);
    len = (kind == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      p = (kind == 1) ? 1'b0 : ($urandom_range(0, 99) < 85);
      send_word(rand_reading(), p, i == len - 1);
    end
  endtask

  // receiver: random stall per result word, or a long hold when requested
  initial begin
    int stall;
    forever begin
      if (hold_req > 0) begin
        out_ready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        do @(posedge clk); while (!out_valid && hold_req == 0);
      end
    end
  end

  always @(posedge clk) begin : check_results
    logic [31:0] want_ceiling;
    bit          want_valid;
    if (rst_n && out_valid && out_ready) begin
      if (exp_ceiling.size() == 0) begin
        $error("unexpected result word: ceiling_speed %h average_valid %b",
               out_ceiling_speed, out_average_valid);
        errors++;
      end else begin
        want_ceiling = exp_ceiling.pop_front();
        want_valid   = exp_valid.pop_front();
        if (out_ceiling_speed !== want_ceiling) begin
          $error("ceiling_speed expected %h actual %h", want_ceiling, out_ceiling_speed);
          errors++;
        end
        if (out_average_valid !== want_valid) begin
          $error("average_valid expected %b actual %b", want_valid, out_average_valid);
          errors++;
        end
        results_checked++;
      end
    end
  end

  // table empty after reset: ceiling holds, previous key still moves
  task automatic test_empty_table();
    send_word(32'd5, 1'b1, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(32'h1234_5678, 1'b0, 1'b1);
  endtask

  task automatic test_register_writes();
    drain_results();
    write_entry(0, -32'sd100, 32'd1000);
    write_entry(1, 32'd0, 32'd2000);
    write_entry(2, 32'd100, 32'd3000);
    write_entry(3, 32'd200, 32'd4000);
    write_reg(cfawc_pkg::REG_ENTRY_COUNT, 64'd4);
    write_reg(cfawc_pkg::REG_INIT_CEIL, {32'hDEAD_BEEF, 32'hABCD_0000});
    // unused indexes must leave everything alone
    write_reg(REG_SPARE_6, {$urandom, $urandom});
    write_reg(REG_SPARE_7, {$urandom, $urandom});
  endtask

  task automatic test_table_walk();
    send_word(32'd150, 1'b1, 1'b1);    // rise across middle entries
    send_word(32'd150, 1'b1, 1'b1);    // same average, no change
    send_word(32'd300, 1'b1, 1'b1);    // above top key
    send_word(-32'sd50, 1'b1, 1'b1);   // fall across several keys
    send_word(-32'sd500, 1'b1, 1'b1);  // below bottom key
    send_word(-32'sd7, 1'b1, 1'b0);    // truncates toward zero
    send_word(32'd0, 1'b1, 1'b1);
  endtask

  task automatic test_reading_extremes();
    send_word(32'h7FFF_FFFF, 1'b1, 1'b1);
    send_word(32'h8000_0000, 1'b1, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b1, 1'b0);  // sum wraps negative
    send_word(32'h7FFF_FFFF, 1'b1, 1'b1);
    send_word(32'h8000_0000, 1'b1, 1'b0);  // sum wraps to zero
    send_word(32'h8000_0000, 1'b1, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b0);  // missing reading, value ignored
    send_word(32'd3, 1'b1, 1'b1);
  endtask

  // oversized entry count, unsorted and duplicate keys, zero ceiling, single entry, empty table
  task automatic test_odd_tables();
    drain_results();
    write_entry(0, 32'd50, 32'd11);
    write_entry(1, -32'sd20, 32'd22);
    write_entry(2, 32'd50, 32'd33);
    write_entry(3, 32'd0, 32'd44);
    write_reg(cfawc_pkg::REG_ENTRY_COUNT, 64'd7);
    write_reg(cfawc_pkg::REG_INIT_CEIL, 64'd0);
    send_word(32'd60, 1'b1, 1'b1);
    send_word(-32'sd30, 1'b1, 1'b1);
    send_word(32'd50, 1'b1, 1'b1);
    drain_results();
    write_reg(cfawc_pkg::REG_ENTRY_COUNT, 64'd1);
    send_word(32'd10, 1'b1, 1'b1);
    send_word(-32'sd10, 1'b1, 1'b1);
    drain_results();
    write_reg(cfawc_pkg::REG_ENTRY_COUNT, 64'd0);
    send_word(32'd7, 1'b1, 1'b1);
  endtask

  task automatic test_random_groups();
    int target;
    for (int phase = 0; phase < 10; phase++) begin
      drain_results();
      load_random_table();
      idle_on = (phase % 4 != 3);
      target = words_sent + 50;
      while (words_sent < target) send_random_group();
    end
    idle_on = 1'b1;
  endtask

  // receiver holds off while single-word groups keep coming, so the input backs up
  task automatic test_output_stall();
    drain_results();
    load_random_table();
    idle_on = 1'b0;
    hold_req = 300;
    repeat (24) send_word(rand_reading(), 1'b1, 1'b1);
    drain_results();
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_register_writes();
    test_table_walk();
    test_reading_extremes();
    test_odd_tables();
    test_random_groups();
    test_output_stall();
    drain_results();
    $display("Sent %0d reading words, checked %0d result words, %0d register writes.",
             words_sent, results_checked, reg_writes);
    $display("Covered table walks, range extremes, odd tables, long groups and a long stall.");
    if (errors == 0) begin
      $display("tb_ceiling_from_average_with_crossing OK");
    end else begin
      $display("tb_ceiling_from_average_with_crossing NOT OK");
    end
    $finish;
  end

endmodule

@@ ceiling_from_average_with_crossing.f @@
hdl/cfawc_pkg.sv
hdl/cfawc_front.sv
hdl/cfawc_fifo.sv
hdl/cfawc_back.sv
hdl/ceiling_from_average_with_crossing.sv
hdl/cfawc_checker.sv
tb/sv/tb_ceiling_from_average_with_crossing.sv
